>>> hw/rtl/bed_pkg.sv
// ----------------------------------------------------------------------------
// bed_pkg
// Shared types, character codes and helpers for the backslash escape decoder.
// ----------------------------------------------------------------------------
package bed_pkg;

   // Character codes
   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] CHAR_A         = 8'h61;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_V         = 8'h76;

   // Control bytes produced by the simple escapes
   localparam logic [7:0] CTRL_BEL = 8'h07;
   localparam logic [7:0] CTRL_BS  = 8'h08;
   localparam logic [7:0] CTRL_HT  = 8'h09;
   localparam logic [7:0] CTRL_LF  = 8'h0A;
   localparam logic [7:0] CTRL_VT  = 8'h0B;
   localparam logic [7:0] CTRL_FF  = 8'h0C;
   localparam logic [7:0] CTRL_CR  = 8'h0D;

   // Configuration register indexes
   localparam int unsigned CSR_COUNT       = 2;
   localparam int unsigned CSR_INDEX_WIDTH = $clog2(CSR_COUNT);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VERBATIM_MODE = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNQUOTE_MODE  = 1'd1;

   // Most result bytes one transaction can cause
   localparam int unsigned MAX_RESULTS  = 4;
   localparam int unsigned RESULT_COUNT_WIDTH = $clog2(MAX_RESULTS + 1);
   localparam int unsigned SLOT_INDEX_WIDTH   = $clog2(MAX_RESULTS);

   typedef struct packed {
      logic verbatim_mode;
      logic unquote_mode;
   } bed_csr_type;

   typedef struct packed {
      logic [RESULT_COUNT_WIDTH-1:0]  count;
      logic [MAX_RESULTS-1:0][7:0]    bytes;
      logic [MAX_RESULTS-1:0]         lasts;
   } bed_result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } bed_hex_type;

   // Hex digit lookup: valid flag and digit value
   function automatic bed_hex_type hex_digit(input logic [7:0] c);
      bed_hex_type h;
      h.valid = 1'b1;
      if (c inside {[8'h30:8'h39]}) begin
         h.value = 4'(c - 8'h30);
      end else if (c inside {[8'h61:8'h66]}) begin
         h.value = 4'(c - 8'h57);
      end else if (c inside {[8'h41:8'h46]}) begin
         h.value = 4'(c - 8'h37);
      end else begin
         h.valid = 1'b0;
         h.value = 4'd0;
      end
      return h;
   endfunction

   function automatic logic is_octal(input logic [7:0] c);
      return c inside {[8'h30:8'h37]};
   endfunction

endpackage

>>> hw/rtl/bed_req_if.sv
// ----------------------------------------------------------------------------
// bed_req_if
// Text byte channel: valid/ready handshake with byte and last flag.
// ----------------------------------------------------------------------------
interface bed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
   modport monitor (input valid, input in_byte, input in_last, input ready);
endinterface

>>> hw/rtl/bed_rsp_if.sv
// ----------------------------------------------------------------------------
// bed_rsp_if
// Decoded byte channel: valid/ready handshake with byte and terminator flag.
// ----------------------------------------------------------------------------
interface bed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink (input valid, input out_byte, input out_last, output ready);
   modport monitor (input valid, input out_byte, input out_last, input ready);
endinterface

>>> hw/rtl/bed_decoder.sv
// ----------------------------------------------------------------------------
// bed_decoder
// Escape scanner: holds the scan state and works out, for the byte offered,
// every result byte it causes and the state that follows.
// ----------------------------------------------------------------------------
module bed_decoder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  bed_pkg::bed_csr_type    csr,
   input  logic [7:0]              in_byte,
   input  logic                    in_last,
   output bed_pkg::bed_result_type result
);
   import bed_pkg::*;

   typedef enum logic [2:0] {
      SCAN_NORMAL   = 3'd0,
      SCAN_ESC      = 3'd1,
      SCAN_HEX_NONE = 3'd2,
      SCAN_HEX      = 3'd3,
      SCAN_OCT      = 3'd4
   } scan_mode_type;

   scan_mode_type mode_ff, mode_in;
   logic [7:0]    value_ff, value_in;
   logic [1:0]    oct_count_ff, oct_count_in;

   logic [RESULT_COUNT_WIDTH-1:0] n;
   bed_hex_type                   hex;
   logic [1:0]                    oct_count_inc;
   logic [7:0]                    oct_value;

   always_comb begin
      hex           = hex_digit(in_byte);
      oct_count_inc = oct_count_ff + 2'd1;
      oct_value     = {value_ff[4:0], in_byte[2:0]};
      mode_in       = mode_ff;
      value_in      = value_ff;
      oct_count_in  = oct_count_ff;
      n             = '0;
      result.bytes  = '0;
      result.lasts  = '0;

      if (csr.verbatim_mode || !csr.unquote_mode) begin
         // Pass-through: copy and drop any pending escape
         mode_in      = SCAN_NORMAL;
         value_in     = '0;
         oct_count_in = '0;
         result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = in_byte;
         n = n + 1'b1;
      end else begin
         // The repeated backslash test marks where the byte falls back to ordinary text
         case (mode_ff)
            SCAN_ESC: begin
               mode_in = SCAN_NORMAL;
               case (in_byte)
                  CHAR_BACKSLASH: begin
                     result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = CHAR_BACKSLASH;
                     n = n + 1'b1;
                  end
                  CHAR_A: begin
                     result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = CTRL_BEL;
                     n = n + 1'b1;
                  end
                  CHAR_B: begin
                     result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = CTRL_BS;
                     n = n + 1'b1;
                  end
                  CHAR_F: begin
                     result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = CTRL_FF;
                     n = n + 1'b1;
                  end
                  CHAR_N: begin
                     result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = CTRL_LF;
                     n = n + 1'b1;
                  end
                  CHAR_R: begin
                     result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = CTRL_CR;
                     n = n + 1'b1;
                  end
                  CHAR_T: begin
                     result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = CTRL_HT;
                     n = n + 1'b1;
                  end
                  CHAR_V: begin
                     result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = CTRL_VT;
                     n = n + 1'b1;
                  end
                  CHAR_X: begin
                     mode_in = SCAN_HEX_NONE;
                  end
                  default: begin
                     if (is_octal(in_byte)) begin
                        value_in     = {5'd0, in_byte[2:0]};
                        oct_count_in = 2'd1;
                        mode_in      = SCAN_OCT;
                     end else begin
                        // Unknown escape: keep the backslash and the byte
                        result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = CHAR_BACKSLASH;
                        n = n + 1'b1;
                        result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = in_byte;
                        n = n + 1'b1;
                     end
                  end
               endcase
            end
            SCAN_HEX_NONE: begin
               if (hex.valid) begin
                  value_in = {4'd0, hex.value};
                  mode_in  = SCAN_HEX;
               end else begin
                  // Backslash-x without digits comes out literally
                  result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = CHAR_BACKSLASH;
                  n = n + 1'b1;
                  result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = CHAR_X;
                  n = n + 1'b1;
                  if (in_byte == CHAR_BACKSLASH && !in_last) begin
                     mode_in = SCAN_ESC;
                  end else begin
                     mode_in = SCAN_NORMAL;
                     result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = in_byte;
                     n = n + 1'b1;
                  end
               end
            end
            SCAN_HEX: begin
               if (hex.valid) begin
                  value_in = {value_ff[3:0], hex.value};
               end else begin
                  result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = value_ff;
                  n = n + 1'b1;
                  if (in_byte == CHAR_BACKSLASH && !in_last) begin
                     mode_in = SCAN_ESC;
                  end else begin
                     mode_in = SCAN_NORMAL;
                     result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = in_byte;
                     n = n + 1'b1;
                  end
               end
            end
            SCAN_OCT: begin
               if (is_octal(in_byte)) begin
                  value_in     = oct_value;
                  oct_count_in = oct_count_inc;
                  // Third digit closes the run at once
                  if (oct_count_inc == 2'd3 || oct_count_inc == 2'd0) begin
                     result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = oct_value;
                     n = n + 1'b1;
                     mode_in = SCAN_NORMAL;
                  end
               end else begin
                  result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = value_ff;
                  n = n + 1'b1;
                  if (in_byte == CHAR_BACKSLASH && !in_last) begin
                     mode_in = SCAN_ESC;
                  end else begin
                     mode_in = SCAN_NORMAL;
                     result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = in_byte;
                     n = n + 1'b1;
                  end
               end
            end
            default: begin
               if (in_byte == CHAR_BACKSLASH && !in_last) begin
                  mode_in = SCAN_ESC;
               end else begin
                  mode_in = SCAN_NORMAL;
                  result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = in_byte;
                  n = n + 1'b1;
               end
            end
         endcase
      end

      if (in_last) begin
         // Flush whatever is pending, then the terminator
         case (mode_in)
            SCAN_HEX_NONE: begin
               result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = CHAR_BACKSLASH;
               n = n + 1'b1;
               result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = CHAR_X;
               n = n + 1'b1;
            end
            SCAN_HEX, SCAN_OCT: begin
               result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = value_in;
               n = n + 1'b1;
            end
            SCAN_ESC: begin
               result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = CHAR_BACKSLASH;
               n = n + 1'b1;
            end
            default: begin
            end
         endcase
         result.bytes[n[SLOT_INDEX_WIDTH-1:0]] = CHAR_NUL;
         result.lasts[n[SLOT_INDEX_WIDTH-1:0]] = 1'b1;
         n = n + 1'b1;
         mode_in      = SCAN_NORMAL;
         value_in     = '0;
         oct_count_in = '0;
      end

      if (mode_in != SCAN_OCT) begin
         oct_count_in = '0;
      end
      result.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= SCAN_NORMAL;
         value_ff     <= '0;
         oct_count_ff <= '0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         value_ff     <= value_in;
         oct_count_ff <= oct_count_in;
      end
   end

endmodule

>>> hw/rtl/backslash_escape_decoder.sv
// ----------------------------------------------------------------------------
// backslash_escape_decoder
// Decodes backslash escapes in a stream of text bytes and appends a zero
// terminator at the end of each text.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Payload
//  req_if    in         valid/ready      in_byte[7:0], in_last
//  rsp_if    out        valid/ready      out_byte[7:0], out_last
//  csr_*     in         write enable     csr_index[0], csr_wdata[0]
//
//  A text byte is decoded in the cycle it is accepted; its results show on
//  rsp_if from the next cycle, one per cycle while rsp_if is ready, from a
//  four-slot shifter. The next transaction waits until the last of k results
//  (k <= 4) is taken; with rsp_if ready, 0 or 1 result gives one per cycle.
//  Synchronous active-high reset empties the shifter and clears scan state;
//  verbatim_mode resets to 0 and unquote_mode to 1.
//  A stalled rsp_if holds its byte; req_if stays ready while the last
//  pending result is being taken.
// ----------------------------------------------------------------------------
module backslash_escape_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   bed_req_if.sink                              req_if,
   bed_rsp_if.source                            rsp_if,
   input  logic                                 csr_wr_en,
   input  logic [bed_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic                                 csr_wdata
);
   import bed_pkg::*;

   bed_csr_type    csr_ff;
   bed_result_type result;

   // Result shifter: slot 0 faces the output
   logic [7:0]                    slot_byte_ff [MAX_RESULTS];
   logic                          slot_last_ff [MAX_RESULTS];
   logic [RESULT_COUNT_WIDTH-1:0] count_ff, count_in;

   logic req_accept;
   logic rsp_take;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.verbatim_mode <= 1'b0;
         csr_ff.unquote_mode  <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_VERBATIM_MODE: csr_ff.verbatim_mode <= csr_wdata;
            CSR_UNQUOTE_MODE:  csr_ff.unquote_mode  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   bed_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .csr     (csr_ff),
      .in_byte (req_if.in_byte),
      .in_last (req_if.in_last),
      .result  (result)
   );

   // Take a new transaction once the shifter drains this cycle
   assign rsp_take     = rsp_if.valid && rsp_if.ready;
   assign req_if.ready = (count_ff == '0) ||
                         (count_ff == RESULT_COUNT_WIDTH'(1) && rsp_if.ready);
   assign req_accept   = req_if.valid && req_if.ready;

   assign rsp_if.valid    = (count_ff != '0);
   assign rsp_if.out_byte = slot_byte_ff[0];
   assign rsp_if.out_last = slot_last_ff[0];

   always_comb begin
      count_in = count_ff;
      if (req_accept) begin
         count_in = result.count;
      end else if (rsp_take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Load on accept, otherwise advance one slot per result taken
   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            slot_byte_ff[i] <= result.bytes[i];
            slot_last_ff[i] <= result.lasts[i];
         end
      end else if (rsp_take) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            slot_byte_ff[i] <= slot_byte_ff[i+1];
            slot_last_ff[i] <= slot_last_ff[i+1];
         end
      end
   end

endmodule

>>> hw/rtl/bed_checker.sv
// ----------------------------------------------------------------------------
// bed_checker
// Port-level checks on the escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bed_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_last,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_byte,
   input  logic       rsp_last
);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_byte) && $stable(rsp_last))
      else $error("bed: stalled result changed");

   // Terminator always carries a zero byte
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_byte == 8'h00)
      else $error("bed: terminator byte not zero");

   // Reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("bed: result pending after reset");

   // A final text byte always yields at least the terminator next cycle
   a_last_yields: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> rsp_valid)
      else $error("bed: no result after final text byte");

endmodule

bind backslash_escape_decoder bed_checker u_bed_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_last  (req_if.in_last),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_byte  (rsp_if.out_byte),
   .rsp_last  (rsp_if.out_last)
);

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the backslash escape decoder. Directed and random
// texts go in on the request channel. A behavioural decoder, kept in step
// with every accepted text byte, predicts the decoded bytes and terminators,
// and each byte taken from the result channel is checked against it. The run
// covers all register settings and both random and forced back-pressure.
// ----------------------------------------------------------------------------
module testbench;
   import bed_pkg::*;

   // Decoder scan state, as tracked by the bench
   typedef enum logic [2:0] {
      SCAN_TEXT,
      SCAN_ESCAPE,
      SCAN_HEX_START,
      SCAN_HEX_DIGITS,
      SCAN_OCTAL
   } scan_state_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } text_char_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } decoded_char_type;

   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_SEVEN    = 8'h37;
   localparam logic [7:0] CHAR_EIGHT    = 8'h38;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F  = 8'h46;
   localparam int         RESET_CYCLES  = 12;
   localparam int         STALL_CYCLES  = 60;
   localparam int         SETTLE_CYCLES = 6;
   localparam int         MAX_REPORTS   = 10;
   localparam int         PHASE_COUNT   = 6;

   // Per phase: random text bytes, register values and idle percentages.
   // Phase 0 runs on the reset values of the registers.
   localparam int   PHASE_ITEMS [PHASE_COUNT] = '{120, 35, 35, 20, 80, 80};
   localparam bit   PHASE_VERB  [PHASE_COUNT] = '{0, 1, 0, 1, 0, 0};
   localparam bit   PHASE_UNQ   [PHASE_COUNT] = '{1, 1, 0, 0, 1, 1};
   localparam int   PHASE_SEND  [PHASE_COUNT] = '{9, 9, 75, 75, 75, 0};
   localparam int   PHASE_RECV  [PHASE_COUNT] = '{75, 75, 9, 9, 9, 0};

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic                       csr_wdata;

   bed_req_if req_if ();
   bed_rsp_if rsp_if ();

   backslash_escape_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Text bytes waiting to be offered, and decoded bytes still owed by the DUT
   text_char_type    text_feed[$];
   decoded_char_type awaited_decoded[$];

   // Behavioural decoder state and its copy of the registers
   scan_state_type scan     = SCAN_TEXT;
   logic [7:0]  esc_value   = 8'h00;
   logic [1:0]  oct_count   = 2'd0;
   logic        verbatim_on = 1'b0;
   logic        unquote_on  = 1'b1;
   int          emitted_now = 0;

   // Traffic shaping
   int   send_idle_pct = 9;
   int   recv_idle_pct = 75;
   int   stall_token   = 0;
   int   stall_seen    = 0;
   int   stall_left    = 0;
   logic req_accepted  = 1'b0;

   // Bookkeeping
   int mismatches      = 0;
   int results_checked = 0;
   int chars_accepted  = 0;
   int texts_queued    = 0;

   string      hex_chars = "0123456789abcdefABCDEF";
   logic [7:0] simple_escapes [8] = '{CHAR_BACKSLASH, CHAR_A, CHAR_B, CHAR_F,
                                      CHAR_N, CHAR_R, CHAR_T, CHAR_V};

   // -------------------------------------------------------------------------
   // Clock: period 10
   // -------------------------------------------------------------------------
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop should the DUT hang
   initial begin
      #2_000_000;
      $display("timeout: %0d decoded bytes still awaited", awaited_decoded.size());
      $display("status: fail");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Behavioural decoder
   // -------------------------------------------------------------------------
   function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] nib);
      nib = 4'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         nib = 4'(c - CHAR_ZERO);
      end else if (c >= CHAR_A && c <= CHAR_F) begin
         nib = 4'(c - CHAR_A + 8'd10);
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         nib = 4'(c - CHAR_UPPER_A + 8'd10);
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // Owe one decoded byte; no text byte yields more than the shifter holds
   task automatic emit_decoded(input logic [7:0] b, input logic fin);
      if (emitted_now < MAX_RESULTS) begin
         awaited_decoded.push_back(decoded_char_type'{b, fin});
         emitted_now++;
      end
   endtask

   // Ordinary text: a backslash opens an escape unless it ends the text
   task automatic take_plain(input logic [7:0] c, input logic fin);
      if (c == CHAR_BACKSLASH && !fin) begin
         scan = SCAN_ESCAPE;
      end else begin
         scan = SCAN_TEXT;
         emit_decoded(c, 1'b0);
      end
   endtask

   task automatic decode_text_char(input logic [7:0] c, input logic fin);
      logic [3:0] nib;
      emitted_now = 0;
      if (verbatim_on || !unquote_on) begin
         // Pass-through: copy the byte, drop any escape in progress
         scan      = SCAN_TEXT;
         esc_value = 8'h00;
         oct_count = 2'd0;
         emit_decoded(c, 1'b0);
      end else begin
         case (scan)
            SCAN_ESCAPE: begin
               scan = SCAN_TEXT;
               case (c)
                  CHAR_BACKSLASH: emit_decoded(CHAR_BACKSLASH, 1'b0);
                  CHAR_A:         emit_decoded(CTRL_BEL, 1'b0);
                  CHAR_B:         emit_decoded(CTRL_BS, 1'b0);
                  CHAR_F:         emit_decoded(CTRL_FF, 1'b0);
                  CHAR_N:         emit_decoded(CTRL_LF, 1'b0);
                  CHAR_R:         emit_decoded(CTRL_CR, 1'b0);
                  CHAR_T:         emit_decoded(CTRL_HT, 1'b0);
                  CHAR_V:         emit_decoded(CTRL_VT, 1'b0);
                  CHAR_X:         scan = SCAN_HEX_START;
                  default: begin
                     if (c >= CHAR_ZERO && c <= CHAR_SEVEN) begin
                        esc_value = {5'd0, c[2:0]};
                        oct_count = 2'd1;
                        scan      = SCAN_OCTAL;
                     end else begin
                        // Unknown escape: keep the backslash and the byte
                        emit_decoded(CHAR_BACKSLASH, 1'b0);
                        emit_decoded(c, 1'b0);
                     end
                  end
               endcase
            end
            SCAN_HEX_START: begin
               if (hex_nibble(c, nib)) begin
                  esc_value = {4'd0, nib};
                  scan      = SCAN_HEX_DIGITS;
               end else begin
                  // No digits after the x: give both back literally
                  emit_decoded(CHAR_BACKSLASH, 1'b0);
                  emit_decoded(CHAR_X, 1'b0);
                  take_plain(c, fin);
               end
            end
            SCAN_HEX_DIGITS: begin
               if (hex_nibble(c, nib)) begin
                  esc_value = {esc_value[3:0], nib};
               end else begin
                  emit_decoded(esc_value, 1'b0);
                  take_plain(c, fin);
               end
            end
            SCAN_OCTAL: begin
               if (c >= CHAR_ZERO && c <= CHAR_SEVEN) begin
                  esc_value = {esc_value[4:0], c[2:0]};
                  oct_count = oct_count + 2'd1;
                  if (oct_count == 2'd3) begin
                     emit_decoded(esc_value, 1'b0);
                     scan = SCAN_TEXT;
                  end
               end else begin
                  emit_decoded(esc_value, 1'b0);
                  take_plain(c, fin);
               end
            end
            default: take_plain(c, fin);
         endcase
      end

      // End of text: flush whatever is pending, then the terminator
      if (fin) begin
         case (scan)
            SCAN_HEX_START: begin
               emit_decoded(CHAR_BACKSLASH, 1'b0);
               emit_decoded(CHAR_X, 1'b0);
            end
            SCAN_HEX_DIGITS, SCAN_OCTAL: emit_decoded(esc_value, 1'b0);
            SCAN_ESCAPE:                 emit_decoded(CHAR_BACKSLASH, 1'b0);
            default: ;
         endcase
         emit_decoded(CHAR_NUL, 1'b1);
         scan      = SCAN_TEXT;
         esc_value = 8'h00;
         oct_count = 2'd0;
      end
      if (scan != SCAN_OCTAL) begin
         oct_count = 2'd0;
      end
   endtask

   function automatic void flag_error(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge.
   // Check the result transaction first, so that a stray result can never
   // consume an expectation raised by a text byte taken at the same edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : channel_monitor
      decoded_char_type want;
      req_accepted <= !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_checked++;
            if (awaited_decoded.size() == 0) begin
               flag_error($sformatf("byte %02h last %0b with nothing awaited",
                                    rsp_if.out_byte, rsp_if.out_last));
            end else begin
               want = awaited_decoded.pop_front();
               if (rsp_if.out_byte !== want.out_byte ||
                   rsp_if.out_last !== want.out_last) begin
                  flag_error($sformatf("got byte %02h last %0b, wanted byte %02h last %0b",
                                       rsp_if.out_byte, rsp_if.out_last,
                                       want.out_byte, want.out_last));
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            chars_accepted++;
            decode_text_char(req_if.in_byte, req_if.in_last);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Driver: change inputs at the falling edge. Hold an offered byte until
   // its transaction completes; only then advance or idle.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : text_driver
      text_char_type next_char;
      if (req_accepted || !req_if.valid) begin
         if (text_feed.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_char = text_feed.pop_front();
            req_if.valid   <= 1'b1;
            req_if.in_byte <= next_char.in_byte;
            req_if.in_last <= next_char.in_last;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result sink: random ready, plus a long hold-off whenever the stimulus
   // process bumps the stall token
   always @(negedge clock) begin : result_sink
      if (stall_token != stall_seen) begin
         stall_seen = stall_token;
         stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   task automatic queue_text(input logic [7:0] chars[$]);
      foreach (chars[i]) begin
         text_feed.push_back(text_char_type'{chars[i], i == chars.size() - 1});
      end
      texts_queued++;
   endtask

   task automatic queue_string(input string s);
      logic [7:0] chars[$];
      for (int i = 0; i < s.len(); i++) begin
         chars.push_back(s[i]);
      end
      queue_text(chars);
   endtask

   // Build one text from a mix of well-formed escapes and noise
   task automatic queue_random_text(output int length);
      logic [7:0] chars[$];
      int         tokens;
      tokens = $urandom_range(1, 8);
      repeat (tokens) begin
         case ($urandom_range(9))
            0, 1, 2: chars.push_back(8'($urandom_range(1, 255)));
            3: begin
               chars.push_back(CHAR_BACKSLASH);
               chars.push_back(simple_escapes[$urandom_range(7)]);
            end
            4: begin
               chars.push_back(CHAR_BACKSLASH);
               chars.push_back(CHAR_X);
               repeat ($urandom_range(0, 4)) begin
                  chars.push_back(hex_chars[$urandom_range(21)]);
               end
            end
            5: begin
               chars.push_back(CHAR_BACKSLASH);
               repeat ($urandom_range(1, 3)) begin
                  chars.push_back(CHAR_ZERO + 8'($urandom_range(7)));
               end
            end
            6: begin
               // Unknown escape, leaning on 8 and 9
               chars.push_back(CHAR_BACKSLASH);
               if ($urandom_range(3) == 0) begin
                  chars.push_back(CHAR_EIGHT + 8'($urandom_range(1)));
               end else begin
                  chars.push_back(8'($urandom_range(1, 255)));
               end
            end
            7: chars.push_back(CHAR_BACKSLASH);
            default: chars.push_back(hex_chars[$urandom_range(21)]);
         endcase
      end
      length = chars.size();
      queue_text(chars);
   endtask

   // Registers change only with the DUT idle
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (index == CSR_VERBATIM_MODE) begin
         verbatim_on = value;
      end else begin
         unquote_on = value;
      end
   endtask

   // Wait for every text byte to be taken and every decoded byte to arrive,
   // then let the pipeline settle
   task automatic await_drain();
      while (text_feed.size() != 0 || req_if.valid || awaited_decoded.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      logic [7:0] extremes[$];
      int         queued;
      int         length;

      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_VERBATIM_MODE;
      csr_wdata      = 1'b0;
      req_if.valid   = 1'b0;
      req_if.in_byte = 8'h00;
      req_if.in_last = 1'b0;
      rsp_if.ready   = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase > 0) begin
            // Pause the sender until the DUT has delivered everything
            await_drain();
            write_register(CSR_VERBATIM_MODE, PHASE_VERB[phase]);
            write_register(CSR_UNQUOTE_MODE, PHASE_UNQ[phase]);
         end
         send_idle_pct = PHASE_SEND[phase];
         recv_idle_pct = PHASE_RECV[phase];

         if (phase == 0) begin
            // Directed texts on the reset settings
            queue_string("\\x");        // backslash-x flushed at end of text
            queue_string("\\x\\n");     // no hex digits, then a fresh escape
            queue_string("\\x1aB\\");   // long hex run, trailing backslash
            queue_string("\\1234");     // third octal digit, then plain text
            queue_string("\\9");        // unknown escape
            queue_string("\\7");        // octal value pending at end of text
            extremes = '{8'hFF, CHAR_NUL, 8'h01};
            queue_text(extremes);
         end

         queued = 0;
         while (queued < PHASE_ITEMS[phase]) begin
            queue_random_text(length);
            queued += length;
         end

         // Last phase: hold the result channel off while the sender keeps
         // offering, so the shifter fills and the request side stalls
         if (phase == PHASE_COUNT - 1) begin
            stall_token++;
         end
      end

      await_drain();

      $display("covered %0d texts: %0d text bytes in, %0d decoded bytes checked",
               texts_queued, chars_accepted, results_checked);
      $display("all four verbatim/unquote settings, random idling and one long stall");
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("status: fail");
      end
      $finish;
   end

endmodule
